@@ rtl/core/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, codes and constant tables of the pattern row sequencer.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int ROWS_DEF    = 64;
    localparam int ROW_IN_W    = 6;
    localparam int ENTRY_W     = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // item opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FPR       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_DC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_LVL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASS_LVL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd5;

    localparam logic [7:0] FPR_RESET = 8'd9;

    // track write actions
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_OFF  = 2'd1;
    localparam logic [1:0] WR_NOTE = 2'd2;

    // row codes
    localparam logic [7:0] CODE_OFF   = 8'd1;
    localparam logic [7:0] DRUM_FIRST = 8'd2;
    localparam logic [7:0] DRUM_LAST  = 8'd4;

    localparam logic [3:0] LEAD_STEP = 4'd2;
    localparam logic [3:0] BASS_STEP = 4'd3;
    localparam logic [1:0] BASS_DUTY = 2'd2;
    localparam logic [3:0] NOISE_STEP = 4'd1;
    localparam logic [2:0] NOISE_RATIO = 3'd6;

    localparam logic [10:0] DIV_MAX = 11'd2047;
    localparam logic [4:0]  BASE_OCT = 5'd4;

    typedef struct packed {
        logic        en;
        logic [7:0]  fpr;
        logic [1:0]  lead_dc;
        logic [3:0]  lead_lvl;
        logic [3:0]  bass_lvl;
        logic [1:0]  intensity;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  wr;
        logic [15:0] ctrl;
        logic [15:0] freq;
    } t_voice;

    // octave-4 divider per semitone
    function automatic logic [8:0] semi_div(input logic [3:0] s);
        logic [8:0] d;
        case (s)
            4'd0:    d = 9'd501;
            4'd1:    d = 9'd473;
            4'd2:    d = 9'd446;
            4'd3:    d = 9'd421;
            4'd4:    d = 9'd398;
            4'd5:    d = 9'd375;
            4'd6:    d = 9'd354;
            4'd7:    d = 9'd334;
            4'd8:    d = 9'd316;
            4'd9:    d = 9'd298;
            4'd10:   d = 9'd281;
            4'd11:   d = 9'd265;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] drum_vol(input logic [1:0] k);
        logic [3:0] v;
        case (k)
            2'd2:    v = 4'd12;
            2'd3:    v = 4'd7;
            2'd0:    v = 4'd10;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] drum_shift(input logic [1:0] k);
        logic [3:0] v;
        case (k)
            2'd2:    v = 4'd7;
            2'd3:    v = 4'd3;
            2'd0:    v = 4'd5;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic drum_width(input logic [1:0] k);
        return (k == 2'd3);
    endfunction

endpackage

@@ rtl/core/prs_if.sv @@
// ----------------------------------------------------------------------------
// prs_if
// Valid/ready channels of the pattern row sequencer: item in, result out.
// ----------------------------------------------------------------------------
interface prs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [5:0] row_addr;
    logic [7:0] lead_byte;
    logic [7:0] bass_byte;
    logic [7:0] drum_byte;
    logic       effect_busy;

    modport source (output valid, op, row_addr, lead_byte, bass_byte, drum_byte,
                    effect_busy, input ready);
    modport sink   (input valid, op, row_addr, lead_byte, bass_byte, drum_byte,
                    effect_busy, output ready);
endinterface

interface prs_out_if;
    logic        valid;
    logic        ready;
    logic        row_fired;
    logic [5:0]  row_index;
    logic [1:0]  lead_write;
    logic [15:0] lead_ctrl;
    logic [15:0] lead_freq;
    logic [1:0]  bass_write;
    logic [15:0] bass_ctrl;
    logic [15:0] bass_freq;
    logic        drum_write;
    logic [15:0] drum_ctrl;
    logic [15:0] drum_freq;

    modport source (output valid, row_fired, row_index, lead_write, lead_ctrl,
                    lead_freq, bass_write, bass_ctrl, bass_freq, drum_write,
                    drum_ctrl, drum_freq, input ready);
    modport sink   (input valid, row_fired, row_index, lead_write, lead_ctrl,
                    lead_freq, bass_write, bass_ctrl, bass_freq, drum_write,
                    drum_ctrl, drum_freq, output ready);
endinterface

@@ rtl/core/prs_ram.sv @@
// ----------------------------------------------------------------------------
// prs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/prs_voice.sv @@
// ----------------------------------------------------------------------------
// prs_voice
// Square track decode: row code to write action, control and divider word.
// ----------------------------------------------------------------------------
module prs_voice import prs_pkg::*; (
    input  logic [7:0] i_code,
    input  logic [3:0] i_vol,
    input  logic [3:0] i_step,
    input  logic [1:0] i_duty,
    output t_voice     o_voice
);
    logic [7:0]  note;
    logic [15:0] prod;
    logic [4:0]  oct;
    logic [7:0]  oct12;
    logic [7:0]  semi_full;
    logic [8:0]  base;
    logic [2:0]  shl;
    logic [4:0]  shr;
    logic [12:0] up;
    logic [8:0]  dn;
    logic [12:0] d;
    logic [10:0] dcl;
    logic [11:0] word;

    always_comb begin
        note      = i_code - DRUM_FIRST;
        prod      = 16'(note) * 16'd171;          // /12 by reciprocal, exact below 256
        oct       = prod[15:11];
        oct12     = {oct, 3'b000} + {1'b0, oct, 2'b00};
        semi_full = note - oct12;
        base      = semi_div(semi_full[3:0]);
        shl       = 3'(BASE_OCT - oct);
        shr       = oct - BASE_OCT;
        up        = 13'(base) << shl;
        dn        = base >> shr;
        if (oct < BASE_OCT) begin
            d = up;
        end else begin
            d = 13'(dn);
        end
        if (d > 13'(DIV_MAX)) begin
            dcl = DIV_MAX;
        end else if (d == 13'd0) begin
            dcl = 11'd1;
        end else begin
            dcl = d[10:0];
        end
        word = 12'd2048 - {1'b0, dcl};

        o_voice = '0;
        if (i_code == CODE_OFF) begin
            o_voice.wr = WR_OFF;
        end else if (i_code >= DRUM_FIRST) begin
            o_voice.wr   = WR_NOTE;
            o_voice.ctrl = {i_vol, i_step, i_duty, 6'b0};
            o_voice.freq = {1'b1, 4'b0, word[10:0]};
        end
    end
endmodule

@@ rtl/core/prs_seq.sv @@
// ----------------------------------------------------------------------------
// prs_seq
// Frame counter and row position; issues pattern reads and load addresses.
// ----------------------------------------------------------------------------
module prs_seq import prs_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    localparam int AW  = $clog2(ROWS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_op,
    input  logic [ROW_IN_W-1:0] i_row_addr,
    input  t_cfg                i_cfg,
    output logic                o_fire,
    output logic [AW-1:0]       o_rd_row,
    output logic [AW-1:0]       o_wr_row
);
    localparam int MW   = ((AW > ROW_IN_W) ? AW : ROW_IN_W) + 1;
    localparam int NSUB = ((2 ** ROW_IN_W) - 1) / ROWS;

    logic [7:0]    r_frame, n_frame;
    logic [AW-1:0] r_row, n_row;
    logic [9:0]    scaled;
    logic [7:0]    speed;
    logic          fire;
    logic [AW:0]   row_inc;
    logic [MW-1:0] wa;

    always_comb begin
        scaled = {2'b00, i_cfg.fpr} + {1'b0, i_cfg.fpr, 1'b0};
        if (i_cfg.intensity[1]) begin
            speed = scaled[9:2];
        end else begin
            speed = i_cfg.fpr;
        end
        if (speed < 8'd2) begin
            speed = 8'd2;
        end
        fire    = (i_op == OP_TICK) && i_cfg.en && (r_frame >= speed);
        row_inc = {1'b0, r_row} + 1'b1;

        n_frame = r_frame;
        n_row   = r_row;
        if (i_accept) begin
            if (i_op == OP_RESTART) begin
                n_frame = '0;
                n_row   = '0;
            end else if (fire) begin
                n_frame = '0;
                n_row   = (row_inc >= (AW+1)'(ROWS)) ? '0 : row_inc[AW-1:0];
            end else if ((i_op == OP_TICK) && i_cfg.en) begin
                n_frame = r_frame + 8'd1;
            end
        end

        wa = MW'(i_row_addr);
        for (int k = 0; k < NSUB; k++) begin
            if (wa >= MW'(ROWS)) begin
                wa = wa - MW'(ROWS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_row   <= '0;
        end else begin
            r_frame <= n_frame;
            r_row   <= n_row;
        end
    end

    assign o_fire   = fire;
    assign o_rd_row = r_row;
    assign o_wr_row = wa[AW-1:0];
endmodule

@@ rtl/core/pattern_row_sequencer.sv @@
// ----------------------------------------------------------------------------
// pattern_row_sequencer
// Three-track pattern sequencer: row loads into a pattern RAM, frame ticks
// that read and decode one row every speed+1 frames.
//
//   channel  dir  role
//   i_in     in   items: tick / load / restart
//   o_out    out  one result per item
//   i_cfg_*  in   register writes, no read-back
//
// One item per cycle while the output is not stalled; at a transfer the pattern
// RAM read data and the stage-1 registers capture the item, and the decode
// result then moves into the output register.
// Reset clears the counters, config and pipeline valid bits; RAM is not cleared.
// A stalled output holds the pipeline; input is taken while the decode
// stage is empty or moving.
// ----------------------------------------------------------------------------
module pattern_row_sequencer import prs_pkg::*; #(
    parameter int ROWS = ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    prs_in_if.sink                i_in,
    prs_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(ROWS);

    t_cfg           r_cfg;
    logic           accept;
    logic           fire;
    logic [AW-1:0]  rd_row;
    logic [AW-1:0]  wr_row;
    logic [ENTRY_W-1:0] rdata;

    logic           r_s1_valid;
    logic           r_s1_fire;
    logic           r_s1_busy;
    logic [5:0]     r_s1_row;
    logic           s1_adv;

    logic           r_o_valid;
    logic [5:0]     row6;
    logic [AW+5:0]  row_ext;
    logic [3:0]     lv;
    logic [4:0]     lv_sum;
    logic           drum_ok;
    t_voice         lead_v, bass_v;

    logic           r_fired;
    logic [5:0]     r_row_idx;
    t_voice         r_lead, r_bass;
    logic           r_drum_wr;
    logic [15:0]    r_drum_ctrl, r_drum_freq;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{en: 1'b0, fpr: FPR_RESET, lead_dc: 2'd0, lead_lvl: 4'd0,
                       bass_lvl: 4'd0, intensity: 2'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENABLE:    r_cfg.en        <= i_cfg_data[0];
                REG_FPR:       r_cfg.fpr       <= i_cfg_data;
                REG_LEAD_DC:   r_cfg.lead_dc   <= i_cfg_data[1:0];
                REG_LEAD_LVL:  r_cfg.lead_lvl  <= i_cfg_data[3:0];
                REG_BASS_LVL:  r_cfg.bass_lvl  <= i_cfg_data[3:0];
                REG_INTENSITY: r_cfg.intensity <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv     = !r_o_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept     = i_in.valid && i_in.ready;

    prs_seq #(.ROWS(ROWS)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_in.op),
        .i_row_addr (i_in.row_addr),
        .i_cfg      (r_cfg),
        .o_fire     (fire),
        .o_rd_row   (rd_row),
        .o_wr_row   (wr_row)
    );

    // load writes and row reads never share a cycle; a read after a load sees it
    prs_ram #(.WIDTH(ENTRY_W), .DEPTH(ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (i_in.op == OP_LOAD)),
        .i_waddr (wr_row),
        .i_wdata ({i_in.drum_byte, i_in.bass_byte, i_in.lead_byte}),
        .i_re    (accept && fire),
        .i_raddr (rd_row),
        .o_rdata (rdata)
    );

    assign row_ext = {6'b0, rd_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_fire <= fire;
            r_s1_busy <= i_in.effect_busy;
            r_s1_row  <= row_ext[5:0];
        end
    end

    // decode
    assign lv_sum = {1'b0, r_cfg.lead_lvl} + ((r_cfg.intensity != 2'd0) ? 5'd2 : 5'd0);
    assign lv     = lv_sum[4] ? 4'd15 : lv_sum[3:0];
    assign row6   = r_s1_row;

    prs_voice u_lead (
        .i_code  (rdata[7:0]),
        .i_vol   (lv),
        .i_step  (LEAD_STEP),
        .i_duty  (r_cfg.lead_dc),
        .o_voice (lead_v)
    );

    prs_voice u_bass (
        .i_code  (rdata[15:8]),
        .i_vol   (r_cfg.bass_lvl),
        .i_step  (BASS_STEP),
        .i_duty  (BASS_DUTY),
        .o_voice (bass_v)
    );

    assign drum_ok = (rdata[23:16] >= DRUM_FIRST) && (rdata[23:16] <= DRUM_LAST)
                     && !r_s1_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_fired     <= r_s1_fire;
            r_row_idx   <= r_s1_fire ? row6 : 6'd0;
            r_lead      <= r_s1_fire ? lead_v : '0;
            r_bass      <= r_s1_fire ? bass_v : '0;
            r_drum_wr   <= r_s1_fire && drum_ok;
            if (r_s1_fire && drum_ok) begin
                r_drum_ctrl <= {drum_vol(rdata[17:16]), NOISE_STEP, 8'h00};
                r_drum_freq <= {1'b1, 7'b0, drum_shift(rdata[17:16]),
                                drum_width(rdata[17:16]), NOISE_RATIO};
            end else begin
                r_drum_ctrl <= '0;
                r_drum_freq <= '0;
            end
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.row_fired  = r_fired;
    assign o_out.row_index  = r_row_idx;
    assign o_out.lead_write = r_lead.wr;
    assign o_out.lead_ctrl  = r_lead.ctrl;
    assign o_out.lead_freq  = r_lead.freq;
    assign o_out.bass_write = r_bass.wr;
    assign o_out.bass_ctrl  = r_bass.ctrl;
    assign o_out.bass_freq  = r_bass.freq;
    assign o_out.drum_write = r_drum_wr;
    assign o_out.drum_ctrl  = r_drum_ctrl;
    assign o_out.drum_freq  = r_drum_freq;
endmodule
